### design/lpfb_pkg.sv
// Shared constants, codes and item types for the length-prefixed frame buffer.
// Used by every module of the block; depends on nothing.
package lpfb_pkg;

   // Field widths of the request and response channels
   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int CLEN_W   = 16;
   localparam int RIDX_W   = 12;
   localparam int STATUS_W = 3;
   localparam int FLEN_W   = 12;

   // Buffer geometry
   localparam int BUF_DEPTH     = 4096;
   localparam int BUF_AW        = $clog2(BUF_DEPTH);
   localparam int POS_W         = BUF_AW + 1;
   localparam int HEADER_BYTES  = 32;
   localparam int MAX_EXTENSION = 2048;
   localparam int FRAME_DEPTH   = HEADER_BYTES + MAX_EXTENSION - 1;
   localparam int FRAME_AW      = $clog2(FRAME_DEPTH);
   localparam int LEN_OFFSET    = 4;
   localparam int LEN_BYTES     = 4;
   localparam int EXT_W         = 8 * LEN_BYTES;
   localparam int SUM_W         = CLEN_W + 1;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POLL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

   // Operations after classification
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_POLL = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DROPPED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOFRAME = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_TAKEN   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FLUSHED = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_READ    = 3'd5;

   // One classified item as it sits in the queue
   typedef struct packed {
      logic [1:0]        op;
      logic [BYTE_W-1:0] data_byte;
      logic              chunk_first;
      logic [CLEN_W-1:0] chunk_len;
      logic [RIDX_W-1:0] read_index;
   } item_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

endpackage

### design/lpfb_front.sv
// Front end: accepts request items, classifies them and queues them.
// Depends on lpfb_pkg.
module lpfb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lpfb_pkg::KIND_W-1:0] req_kind,
   input  logic [lpfb_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                      req_chunk_first,
   input  logic [lpfb_pkg::CLEN_W-1:0] req_chunk_len,
   input  logic [lpfb_pkg::RIDX_W-1:0] req_read_index,
   output lpfb_pkg::q_head_type      q_head,
   input  logic                      q_pop
);
   import lpfb_pkg::*;

   item_type   q_item_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;
   logic       pop;

   // Classify the incoming item
   always_comb begin
      new_item.data_byte   = req_data_byte;
      new_item.chunk_first = req_chunk_first;
      new_item.chunk_len   = req_chunk_len;
      new_item.read_index  = req_read_index;
      case (req_kind)
         KIND_BYTE: new_item.op = OP_BYTE;
         KIND_POLL: new_item.op = OP_POLL;
         KIND_READ: new_item.op = OP_READ;
         default:   new_item.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && (count_ff != 2'd0);

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.item  = q_item_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         q_item_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### design/lpfb_back.sv
// Back end: executes queued items against the packet store and frame store,
// and holds the response register. Depends on lpfb_pkg.
module lpfb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lpfb_pkg::q_head_type          q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpfb_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpfb_pkg::FLEN_W-1:0]   rsp_frame_len,
   output logic [lpfb_pkg::BYTE_W-1:0]   rsp_read_byte
);
   import lpfb_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_BYTE    = 4'd1;
   localparam logic [3:0] S_STORE   = 4'd2;
   localparam logic [3:0] S_MV_RD   = 4'd3;
   localparam logic [3:0] S_MV_WR   = 4'd4;
   localparam logic [3:0] S_POLL    = 4'd5;
   localparam logic [3:0] S_EXT_RD  = 4'd6;
   localparam logic [3:0] S_EXT_WR  = 4'd7;
   localparam logic [3:0] S_EXT_CHK = 4'd8;
   localparam logic [3:0] S_CP_RD   = 4'd9;
   localparam logic [3:0] S_CP_WR   = 4'd10;
   localparam logic [3:0] S_READ    = 4'd11;
   localparam logic [3:0] S_READ2   = 4'd12;
   localparam logic [3:0] S_RESP    = 4'd13;

   // Memories
   logic [BYTE_W-1:0] packet_mem [BUF_DEPTH];
   logic [BYTE_W-1:0] frame_mem  [FRAME_DEPTH];

   logic [3:0]          state_ff, state_in;
   logic [POS_W-1:0]    wp_ff, wp_in;
   logic [POS_W-1:0]    rp_ff, rp_in;
   logic                acc_ff, acc_in;
   logic [CLEN_W-1:0]   left_ff, left_in;
   logic [FLEN_W-1:0]   taken_ff, taken_in;
   logic [POS_W-1:0]    cnt_ff, cnt_in;
   logic [EXT_W-1:0]    ext_ff, ext_in;
   logic [FLEN_W-1:0]   tot_ff, tot_in;
   item_type            cur_ff, cur_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FLEN_W-1:0]   res_flen_ff, res_flen_in;
   logic [BYTE_W-1:0]   res_rbyte_ff, res_rbyte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FLEN_W-1:0]   rsp_flen_ff, rsp_flen_in;
   logic [BYTE_W-1:0]   rsp_rbyte_ff, rsp_rbyte_in;

   logic                pk_we;
   logic [BUF_AW-1:0]   pk_waddr;
   logic [BYTE_W-1:0]   pk_wdata;
   logic [BUF_AW-1:0]   pk_raddr;
   logic [BYTE_W-1:0]   pk_rdata_ff;
   logic                fr_we;
   logic [FRAME_AW-1:0] fr_waddr;
   logic                fr_re;
   logic [FRAME_AW-1:0] fr_raddr;
   logic [BYTE_W-1:0]   fr_rdata_ff;

   logic [POS_W-1:0]    unread;
   logic [POS_W-1:0]    cnt_inc;
   logic [SUM_W-1:0]    end_sum;
   logic [SUM_W-1:0]    unread_sum;
   logic [FLEN_W-1:0]   total;
   logic                out_free;
   logic                idx_ok;

   assign unread     = wp_ff - rp_ff;
   assign cnt_inc    = cnt_ff + POS_W'(1);
   assign end_sum    = SUM_W'(wp_ff) + SUM_W'(cur_ff.chunk_len);
   assign unread_sum = SUM_W'(unread) + SUM_W'(cur_ff.chunk_len);
   assign total      = ext_ff[FLEN_W-1:0] + FLEN_W'(HEADER_BYTES);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign idx_ok     = (cur_ff.read_index < taken_ff);

   // Sequence one item at a time
   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      acc_in        = acc_ff;
      left_in       = left_ff;
      taken_in      = taken_ff;
      cnt_in        = cnt_ff;
      ext_in        = ext_ff;
      tot_in        = tot_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_flen_in   = res_flen_ff;
      res_rbyte_in  = res_rbyte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_flen_in   = rsp_flen_ff;
      rsp_rbyte_in  = rsp_rbyte_ff;
      q_pop         = 1'b0;
      pk_we         = 1'b0;
      pk_waddr      = wp_ff[BUF_AW-1:0];
      pk_wdata      = cur_ff.data_byte;
      pk_raddr      = rp_ff[BUF_AW-1:0] + cnt_ff[BUF_AW-1:0];
      fr_we         = 1'b0;
      fr_waddr      = cnt_ff[FRAME_AW-1:0];
      fr_re         = 1'b0;
      fr_raddr      = cur_ff.read_index[FRAME_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            res_flen_in  = '0;
            res_rbyte_in = '0;
            if (q_head.valid) begin
               q_pop  = 1'b1;
               cur_in = q_head.item;
               case (q_head.item.op)
                  OP_BYTE: state_in = S_BYTE;
                  OP_POLL: state_in = S_POLL;
                  OP_READ: state_in = S_READ;
                  default: begin
                     res_status_in = STAT_NOFRAME;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         // Decide the fate of a new chunk
         S_BYTE: begin
            if (cur_ff.chunk_first) begin
               acc_in  = 1'b0;
               left_in = '0;
               if (cur_ff.chunk_len == '0) begin
                  res_status_in = STAT_DROPPED;
                  state_in      = S_RESP;
               end else if (end_sum <= SUM_W'(BUF_DEPTH)) begin
                  acc_in   = 1'b1;
                  left_in  = cur_ff.chunk_len;
                  state_in = S_STORE;
               end else if (unread_sum >= SUM_W'(BUF_DEPTH)) begin
                  res_status_in = STAT_DROPPED;
                  state_in      = S_RESP;
               end else begin
                  acc_in  = 1'b1;
                  left_in = cur_ff.chunk_len;
                  cnt_in  = '0;
                  if (unread == '0) begin
                     wp_in    = '0;
                     rp_in    = '0;
                     state_in = S_STORE;
                  end else begin
                     state_in = S_MV_RD;
                  end
               end
            end else begin
               state_in = S_STORE;
            end
         end

         // Store the byte or drop it
         S_STORE: begin
            if (!acc_ff || left_ff == '0 || wp_ff >= POS_W'(BUF_DEPTH)) begin
               res_status_in = STAT_DROPPED;
            end else begin
               pk_we         = 1'b1;
               wp_in         = wp_ff + POS_W'(1);
               left_in       = left_ff - CLEN_W'(1);
               res_status_in = STAT_STORED;
            end
            state_in = S_RESP;
         end

         // Compact unread bytes to the front, read in S_MV_RD, written in S_MV_WR
         S_MV_RD: begin
            state_in = S_MV_WR;
         end
         S_MV_WR: begin
            pk_we    = 1'b1;
            pk_waddr = cnt_ff[BUF_AW-1:0];
            pk_wdata = pk_rdata_ff;
            cnt_in   = cnt_inc;
            if (cnt_inc == unread) begin
               wp_in    = unread;
               rp_in    = '0;
               state_in = S_STORE;
            end else begin
               state_in = S_MV_RD;
            end
         end

         S_POLL: begin
            if (unread < POS_W'(HEADER_BYTES)) begin
               res_status_in = STAT_NOFRAME;
               state_in      = S_RESP;
            end else begin
               cnt_in   = '0;
               state_in = S_EXT_RD;
            end
         end

         // Gather the little-endian extension length
         S_EXT_RD: begin
            pk_raddr = rp_ff[BUF_AW-1:0] + BUF_AW'(LEN_OFFSET) + cnt_ff[BUF_AW-1:0];
            state_in = S_EXT_WR;
         end
         S_EXT_WR: begin
            ext_in = {pk_rdata_ff, ext_ff[EXT_W-1:BYTE_W]};
            cnt_in = cnt_inc;
            if (cnt_ff == POS_W'(LEN_BYTES - 1)) begin
               state_in = S_EXT_CHK;
            end else begin
               state_in = S_EXT_RD;
            end
         end

         S_EXT_CHK: begin
            if (ext_ff >= EXT_W'(MAX_EXTENSION)) begin
               wp_in         = '0;
               rp_in         = '0;
               res_status_in = STAT_FLUSHED;
               state_in      = S_RESP;
            end else if (unread < POS_W'(total)) begin
               res_status_in = STAT_NOFRAME;
               state_in      = S_RESP;
            end else begin
               tot_in   = total;
               cnt_in   = '0;
               state_in = S_CP_RD;
            end
         end

         // Copy the frame into the frame store
         S_CP_RD: begin
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            fr_we  = 1'b1;
            cnt_in = cnt_inc;
            if (cnt_inc == POS_W'(tot_ff)) begin
               rp_in         = rp_ff + POS_W'(tot_ff);
               taken_in      = tot_ff;
               res_status_in = STAT_TAKEN;
               res_flen_in   = tot_ff;
               state_in      = S_RESP;
            end else begin
               state_in = S_CP_RD;
            end
         end

         // Read one byte of the taken frame
         S_READ: begin
            fr_re    = idx_ok;
            state_in = S_READ2;
         end
         S_READ2: begin
            res_status_in = STAT_READ;
            res_rbyte_in  = idx_ok ? fr_rdata_ff : '0;
            state_in      = S_RESP;
         end

         // Hand the result to the output register
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_flen_in   = res_flen_ff;
               rsp_rbyte_in  = res_rbyte_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         acc_ff       <= 1'b0;
         left_ff      <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      ext_ff        <= ext_in;
      tot_ff        <= tot_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_flen_ff   <= res_flen_in;
      res_rbyte_ff  <= res_rbyte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_flen_ff   <= rsp_flen_in;
      rsp_rbyte_ff  <= rsp_rbyte_in;
   end

   // Packet store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pk_we) begin
         packet_mem[pk_waddr] <= pk_wdata;
      end
      pk_rdata_ff <= packet_mem[pk_raddr];
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_mem[fr_waddr] <= pk_rdata_ff;
      end
      if (fr_re) begin
         fr_rdata_ff <= frame_mem[fr_raddr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_frame_len = rsp_flen_ff;
   assign rsp_read_byte = rsp_rbyte_ff;

endmodule

### design/length_prefixed_frame_buffer.sv
// Top level of the length-prefixed frame buffer: front end, queue and back end.
// Depends on lpfb_pkg, lpfb_front and lpfb_back.
//
// Buffers received chunk bytes in a 4096-byte packet store and cuts them into
// frames of a 32-byte header plus the little-endian extension length held in
// header bytes 4..7. Every item returns exactly one response. Items are taken
// into a two-entry queue and executed one at a time by a sequencer that owns
// the packet store and the frame store, each with one write port and one
// registered read port. A byte item passes the chunk decision and, unless its
// chunk is dropped there, any compaction of unread bytes to the front and the
// store step; a poll checks for a header, gathers the extension length, checks
// it and copies the frame; a read fetches one byte of the taken frame. Each
// moved or copied byte is read in one state and written in the next. An
// accepted item is registered in the queue before the sequencer can take it,
// and each result is loaded into the response register. A stalled response
// holds the sequencer. There is no clearing pass after reset.
module length_prefixed_frame_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lpfb_pkg::KIND_W-1:0]   req_kind,
   input  logic [lpfb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_chunk_first,
   input  logic [lpfb_pkg::CLEN_W-1:0]   req_chunk_len,
   input  logic [lpfb_pkg::RIDX_W-1:0]   req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpfb_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpfb_pkg::FLEN_W-1:0]   rsp_frame_len,
   output logic [lpfb_pkg::BYTE_W-1:0]   rsp_read_byte
);
   import lpfb_pkg::*;

   q_head_type q_head;
   logic       q_pop;

   lpfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_chunk_first (req_chunk_first),
      .req_chunk_len   (req_chunk_len),
      .req_read_index  (req_read_index),
      .q_head          (q_head),
      .q_pop           (q_pop)
   );

   lpfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_frame_len (rsp_frame_len),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule

### design/lpfb_checker.sv
// Port-level checks on the response channel of the frame buffer, and the bind
// that attaches them to the top level. Depends on lpfb_pkg.
module lpfb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lpfb_pkg::STATUS_W-1:0] rsp_status,
   input logic [lpfb_pkg::FLEN_W-1:0]   rsp_frame_len,
   input logic [lpfb_pkg::BYTE_W-1:0]   rsp_read_byte
);
   import lpfb_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_len) && $stable(rsp_read_byte))
      else $error("stalled response changed");

   // Only a taken frame carries a length
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_TAKEN |-> rsp_frame_len == '0)
      else $error("frame length on non-taken response");

   // Only a read carries a data byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_READ |-> rsp_read_byte == '0)
      else $error("read byte on non-read response");

   // A taken frame holds at least a header and fits the frame store
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_TAKEN |->
         rsp_frame_len >= FLEN_W'(HEADER_BYTES) && rsp_frame_len <= FLEN_W'(FRAME_DEPTH))
      else $error("taken frame length out of range");

endmodule

bind length_prefixed_frame_buffer lpfb_checker u_lpfb_checker (.*);

### test/testbench.sv
// Self-checking testbench for length_prefixed_frame_buffer.
// Depends on lpfb_pkg and the RTL; predicts each response with its own deframer model or a
// directed row's fixed reply; compares field by field under random idling on both channels.
module testbench;
   import lpfb_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_ITEMS  = 450;
   localparam int LARGE_EXT     = 300;
   localparam int HOLD_AT       = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 50;
   localparam int TIMEOUT_UNITS = 10_000_000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
      logic              chunk_first;
      logic [CLEN_W-1:0] chunk_len;
      logic [RIDX_W-1:0] read_index;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FLEN_W-1:0]   frame_len;
      logic [BYTE_W-1:0]   read_byte;
   } reply_type;

   typedef struct packed {
      request_type req;
      logic        given;
      reply_type   reply;
   } directed_row_type;

   // Opening items: idle block, bad bytes, chunk fates at the store boundary, cut-short chunk
   localparam int DIRECTED_COUNT = 19;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{KIND_READ,  8'h00, 1'b0, 16'h0000, 12'd0},    1'b1, '{STAT_READ,    12'd0, 8'h00}},
      '{'{KIND_READ,  8'hFF, 1'b1, 16'hFFFF, 12'd2078}, 1'b1, '{STAT_READ,    12'd0, 8'h00}},
      '{'{KIND_POLL,  8'h00, 1'b0, 16'h0000, 12'd0},    1'b1, '{STAT_NOFRAME, 12'd0, 8'h00}},
      '{'{KIND_SPARE, 8'h5A, 1'b1, 16'h1234, 12'hFFF},  1'b1, '{STAT_NOFRAME, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'hA5, 1'b0, 16'h0000, 12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'hFF, 1'b1, 16'd0,    12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h00, 1'b1, 16'hFFFF, 12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h55, 1'b0, 16'd7,    12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'hFF, 1'b1, 16'd1,    12'd0},    1'b1, '{STAT_STORED,  12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h00, 1'b0, 16'd1,    12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h00, 1'b1, 16'd4096, 12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h00, 1'b1, 16'd4095, 12'd0},    1'b1, '{STAT_STORED,  12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h7F, 1'b0, 16'd0,    12'd0},    1'b0, '{STAT_STORED,  12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h80, 1'b1, 16'd3,    12'd0},    1'b1, '{STAT_STORED,  12'd0, 8'h00}},
      '{'{KIND_POLL,  8'h00, 1'b0, 16'd0,    12'd0},    1'b1, '{STAT_NOFRAME, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h01, 1'b0, 16'd0,    12'd0},    1'b0, '{STAT_STORED,  12'd0, 8'h00}},
      '{'{KIND_READ,  8'h00, 1'b0, 16'd0,    12'hFFF},  1'b1, '{STAT_READ,    12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'hC3, 1'b1, 16'd4092, 12'd0},    1'b1, '{STAT_DROPPED, 12'd0, 8'h00}},
      '{'{KIND_BYTE,  8'h3C, 1'b1, 16'd4090, 12'd0},    1'b1, '{STAT_STORED,  12'd0, 8'h00}}
   };

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind        = '0;
   logic [BYTE_W-1:0]   req_data_byte   = '0;
   logic                req_chunk_first = 1'b0;
   logic [CLEN_W-1:0]   req_chunk_len   = '0;
   logic [RIDX_W-1:0]   req_read_index  = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [FLEN_W-1:0]   rsp_frame_len;
   logic [BYTE_W-1:0]   rsp_read_byte;

   // Fixed expectation that travels with a directed item
   logic      pinned_valid = 1'b0;
   reply_type pinned_reply = '0;

   // Deframer model state
   logic [7:0] held_bytes  [BUF_DEPTH];
   logic [7:0] taken_frame [FRAME_DEPTH];
   int         fill_pos        = 0;
   int         drain_pos       = 0;
   logic       chunk_live      = 1'b0;
   int         chunk_remaining = 0;
   int         taken_len       = 0;

   reply_type  pending_replies [$];
   reply_type  predicted;
   reply_type  observed;
   logic [7:0] frame_image [$];
   int         items_sent  = 0;
   int         error_count = 0;

   length_prefixed_frame_buffer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_chunk_first (req_chunk_first),
      .req_chunk_len   (req_chunk_len),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_frame_len   (rsp_frame_len),
      .rsp_read_byte   (rsp_read_byte)
   );

   always #5 clock = ~clock;

   // Advance the deframer model by one item and return its response
   function automatic reply_type deframe_step(input request_type it);
      reply_type   r;
      int          unread;
      int          total;
      int          i;
      logic [31:0] ext;
      r = '0;
      case (it.kind)
         KIND_BYTE: begin
            r.status = STAT_DROPPED;
            // Decide the chunk's fate on its first byte
            if (it.chunk_first) begin
               unread = fill_pos - drain_pos;
               chunk_live = 1'b0;
               chunk_remaining = int'(it.chunk_len);
               if (it.chunk_len != 0) begin
                  if (fill_pos + it.chunk_len <= BUF_DEPTH) begin
                     chunk_live = 1'b1;
                  end else if (unread + it.chunk_len < BUF_DEPTH) begin
                     // Compact unread bytes to the front
                     for (i = 0; i < unread; i++) held_bytes[i] = held_bytes[drain_pos + i];
                     fill_pos = unread;
                     drain_pos = 0;
                     chunk_live = 1'b1;
                  end
               end
            end
            if (chunk_live && chunk_remaining != 0 && fill_pos < BUF_DEPTH) begin
               held_bytes[fill_pos] = it.data_byte;
               fill_pos++;
               chunk_remaining--;
               r.status = STAT_STORED;
            end
         end
         KIND_POLL: begin
            r.status = STAT_NOFRAME;
            unread = fill_pos - drain_pos;
            if (unread >= HEADER_BYTES) begin
               ext = {held_bytes[drain_pos + LEN_OFFSET + 3], held_bytes[drain_pos + LEN_OFFSET + 2],
                      held_bytes[drain_pos + LEN_OFFSET + 1], held_bytes[drain_pos + LEN_OFFSET]};
               if (ext >= MAX_EXTENSION) begin
                  // Flush the whole buffer, keep the taken frame
                  fill_pos = 0;
                  drain_pos = 0;
                  r.status = STAT_FLUSHED;
               end else begin
                  total = int'(ext) + HEADER_BYTES;
                  if (unread >= total) begin
                     for (i = 0; i < total; i++) taken_frame[i] = held_bytes[drain_pos + i];
                     drain_pos += total;
                     taken_len = total;
                     r.status = STAT_TAKEN;
                     r.frame_len = FLEN_W'(total);
                  end
               end
            end
         end
         KIND_READ: begin
            r.status = STAT_READ;
            if (it.read_index < taken_len && it.read_index < FRAME_DEPTH)
               r.read_byte = taken_frame[it.read_index];
         end
         default: r.status = STAT_NOFRAME;
      endcase
      return r;
   endfunction

   // Predict on every accepted item, check every accepted response
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predicted = deframe_step(request_type'{req_kind, req_data_byte, req_chunk_first,
                                                req_chunk_len, req_read_index});
         pending_replies.push_back(pinned_valid ? pinned_reply : predicted);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         observed = '{rsp_status, rsp_frame_len, rsp_read_byte};
         if (pending_replies.size() == 0) begin
            $error("response with no item outstanding: status %0d", rsp_status);
            error_count++;
         end else begin
            predicted = pending_replies.pop_front();
            if (observed.status !== predicted.status) begin
               $error("status: expected %0d, got %0d", predicted.status, observed.status);
               error_count++;
            end
            if (observed.frame_len !== predicted.frame_len) begin
               $error("frame_len: expected %0d, got %0d", predicted.frame_len,
                      observed.frame_len);
               error_count++;
            end
            if (observed.read_byte !== predicted.read_byte) begin
               $error("read_byte: expected %0h, got %0h", predicted.read_byte,
                      observed.read_byte);
               error_count++;
            end
         end
      end
   end

   // Offer one item after a random gap, or none in burst stretches, and hold it until accepted
   task automatic send_item(input request_type it, input logic given, input reply_type reply);
      int gap;
      gap = (((items_sent / 64) % 4) == 3) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= it.kind;
      req_data_byte   <= it.data_byte;
      req_chunk_first <= it.chunk_first;
      req_chunk_len   <= it.chunk_len;
      req_read_index  <= it.read_index;
      pinned_valid    <= given;
      pinned_reply    <= reply;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (it.kind != KIND_SPARE) items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic first, input int clen);
      request_type it;
      it = '{KIND_BYTE, value, first, CLEN_W'(clen), RIDX_W'($urandom)};
      send_item(it, 1'b0, '0);
   endtask

   task automatic send_poll();
      request_type it;
      it = '{KIND_POLL, BYTE_W'($urandom), 1'($urandom), CLEN_W'($urandom), RIDX_W'($urandom)};
      send_item(it, 1'b0, '0);
   endtask

   task automatic send_read(input int idx);
      request_type it;
      it = '{KIND_READ, BYTE_W'($urandom), 1'($urandom), CLEN_W'($urandom), RIDX_W'(idx)};
      send_item(it, 1'b0, '0);
   endtask

   // Build a frame image: random header with the extension length at bytes 4..7, random body
   task automatic compose_frame(input logic [31:0] ext, input int body_len);
      int i;
      frame_image.delete();
      for (i = 0; i < HEADER_BYTES + body_len; i++) frame_image.push_back(8'($urandom));
      for (i = 0; i < LEN_BYTES; i++) frame_image[LEN_OFFSET + i] = ext[8*i +: 8];
   endtask

   // Send the frame image as random chunks; tail over-announces the last chunk
   task automatic send_in_chunks(input int max_chunk, input int tail, input logic probe);
      int pos;
      int n;
      int announce;
      int k;
      pos = 0;
      while (pos < frame_image.size()) begin
         n = $urandom_range(1, max_chunk);
         if (n > frame_image.size() - pos) n = frame_image.size() - pos;
         announce = n;
         if (pos + n == frame_image.size()) announce += tail;
         else if ($urandom_range(0, 7) == 0) announce += $urandom_range(1, 16);
         for (k = 0; k < n; k++)
            send_byte(frame_image[pos + k], k == 0, (k == 0) ? announce : $urandom);
         pos += n;
         // Poll on an incomplete frame now and then
         if (probe && pos < frame_image.size() && $urandom_range(0, 9) == 0) send_poll();
      end
   endtask

   initial begin : stimulus
      int          row;
      int          pick;
      int          random_start;
      logic [31:0] ext;
      request_type junk;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_COUNT; row++)
         send_item(DIRECTED_ROWS[row].req, DIRECTED_ROWS[row].given, DIRECTED_ROWS[row].reply);

      // Flush leftovers with an all-ones extension length
      compose_frame(32'hFFFF_FFFF, 0);
      send_in_chunks(16, 0, 1'b0);
      send_poll();

      // One long frame, read at both ends, past the end and at the top of the frame store
      compose_frame(LARGE_EXT, LARGE_EXT);
      send_in_chunks(256, 0, 1'b1);
      send_poll();
      send_read(0);
      send_read(LARGE_EXT + HEADER_BYTES - 1);
      send_read(LARGE_EXT + HEADER_BYTES);
      send_read(FRAME_DEPTH - 1);
      repeat (3) send_read($urandom_range(0, LARGE_EXT + HEADER_BYTES - 1));

      random_start = items_sent;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // Well-formed frame, mostly small
            ext = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
            compose_frame(ext, ext);
            send_in_chunks($urandom_range(0, 1) ? 8 : 48, 0, 1'b1);
            if ($urandom_range(0, 5) != 0) begin
               repeat ($urandom_range(1, 2)) send_poll();
               repeat ($urandom_range(0, 3))
                  send_read(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) :
                            $urandom_range(0, ext + HEADER_BYTES - 1));
            end
         end else if (pick < 82) begin
            // Oversize header, sometimes flushed in the middle of its chunk
            ext = ($urandom_range(0, 3) == 0) ? MAX_EXTENSION :
                  $urandom_range(MAX_EXTENSION, 32'hFFFF_FFFF);
            compose_frame(ext, 0);
            if ($urandom_range(0, 1)) begin
               send_in_chunks(HEADER_BYTES, 8, 1'b0);
               send_poll();
               repeat (8) send_byte(8'($urandom), 1'b0, $urandom);
               send_poll();
            end else begin
               send_in_chunks(16, 0, 1'b0);
               send_poll();
            end
         end else begin
            // Loose item with arbitrary fields
            junk.kind        = KIND_W'($urandom_range(0, 3));
            junk.data_byte   = BYTE_W'($urandom);
            junk.chunk_first = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
               0:       junk.chunk_len = CLEN_W'($urandom);
               1:       junk.chunk_len = CLEN_W'($urandom_range(0, 64));
               default: junk.chunk_len = CLEN_W'($urandom_range(3000, BUF_DEPTH));
            endcase
            junk.read_index  = RIDX_W'($urandom);
            send_item(junk, 1'b0, '0);
         end
      end

      // Drain and report
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Response side: random stalls, bursts without stalls, one long hold-off
   initial begin : response_side
      int stall;
      int got;
      got = 0;
      while (reset) @(posedge clock);
      forever begin
         if (got == HOLD_AT) stall = HOLD_CYCLES;
         else if (((got / 64) % 4) == 1) stall = 0;
         else stall = $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got++;
      end
   end

   initial begin : watchdog
      #TIMEOUT_UNITS;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### length_prefixed_frame_buffer.f
design/lpfb_pkg.sv
design/lpfb_front.sv
design/lpfb_back.sv
design/length_prefixed_frame_buffer.sv
design/lpfb_checker.sv
test/testbench.sv
